FILE: design/b64se_pkg.sv
// Shared types, constants and the alphabet function of the base64 stream encoder.
// No dependencies.
package b64se_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [6:0] PAD_CHAR   = 7'h3D;
   localparam logic [6:0] PLUS_CHAR  = 7'h2B;
   localparam logic [6:0] SLASH_CHAR = 7'h2F;

   typedef struct packed {
      logic [23:0] data;
      logic [1:0]  cnt;   // bytes in the group minus one
      logic        last;
   } group_type;

   function automatic logic [6:0] b64_char(input logic [5:0] idx);
      logic [6:0] r;
      if (idx < 6'd26) begin
         r = 7'd65 + {1'b0, idx};
      end else if (idx < 6'd52) begin
         r = 7'd71 + {1'b0, idx};
      end else if (idx < 6'd62) begin
         r = {1'b0, idx} - 7'd4;
      end else if (idx == 6'd62) begin
         r = PLUS_CHAR;
      end else begin
         r = SLASH_CHAR;
      end
      return r;
   endfunction

endpackage

FILE: design/b64se_front.sv
// Front end: accepts bytes, holds the pending pair and closes groups.
// Depends on b64se_pkg.
module b64se_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_last_byte,
   input  logic                 q_full,
   output logic                 q_push,
   output b64se_pkg::group_type q_wdata
);
   import b64se_pkg::*;

   logic [15:0] pending_ff, pending_in;
   logic [1:0]  count_ff, count_in;
   logic        accept;
   logic        closes;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign closes    = req_last_byte || (count_ff == 2'd2);
   assign q_push    = accept && closes;

   always_comb begin
      q_wdata.cnt  = count_ff;
      q_wdata.last = req_last_byte;
      unique case (count_ff)
         2'd0:    q_wdata.data = {req_data_byte, 16'h0000};
         2'd1:    q_wdata.data = {pending_ff[15:8], req_data_byte, 8'h00};
         default: q_wdata.data = {pending_ff, req_data_byte};
      endcase
   end

   always_comb begin
      pending_in = pending_ff;
      count_in   = count_ff;
      if (accept) begin
         if (closes) begin
            count_in = 2'd0;
         end else if (count_ff == 2'd0) begin
            pending_in = {req_data_byte, 8'h00};
            count_in   = 2'd1;
         end else begin
            pending_in = {pending_ff[15:8], req_data_byte};
            count_in   = 2'd2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      pending_ff <= pending_in;
   end

endmodule

FILE: design/b64se_queue.sv
// Short group queue between front and back end.
// Depends on b64se_pkg.
module b64se_queue #(
   parameter int Depth = b64se_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  b64se_pkg::group_type wdata,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output b64se_pkg::group_type rdata
);
   import b64se_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   group_type         mem [Depth];
   logic [PtrW-1:0]   wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == CntW'(Depth));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign rdata     = mem[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PtrW'(Depth - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PtrW'(Depth - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         mem[wptr_ff] <= wdata;
      end
   end

endmodule

FILE: design/b64se_back.sv
// Back end: turns a group into four registered characters, one per cycle unless stalled.
// Depends on b64se_pkg.
module b64se_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_not_empty,
   input  b64se_pkg::group_type q_rdata,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [6:0]           rsp_out_char,
   output logic                 rsp_last_char
);
   import b64se_pkg::*;

   group_type   group_ff, group_in;
   logic        busy_ff, busy_in;
   logic [1:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   logic [6:0]  char_ff, char_in;
   logic        lastc_ff, lastc_in;
   logic        slot_free, emit, done;
   logic [5:0]  sextet;

   assign slot_free = !valid_ff || rsp_ready;
   assign emit      = busy_ff && slot_free;
   assign done      = emit && (idx_ff == 2'd3);
   assign q_pop     = q_not_empty && (!busy_ff || done);

   always_comb begin
      unique case (idx_ff)
         2'd0:    sextet = group_ff.data[23:18];
         2'd1:    sextet = group_ff.data[17:12];
         2'd2:    sextet = group_ff.data[11:6];
         default: sextet = group_ff.data[5:0];
      endcase
   end

   always_comb begin
      group_in = group_ff;
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      lastc_in = lastc_ff;
      if (rsp_ready) begin
         valid_in = 1'b0;
      end
      if (emit) begin
         valid_in = 1'b1;
         // pad where position exceeds byte count
         if ({1'b0, idx_ff} >= ({1'b0, group_ff.cnt} + 3'd2)) begin
            char_in = PAD_CHAR;
         end else begin
            char_in = b64_char(sextet);
         end
         lastc_in = (idx_ff == 2'd3) && group_ff.last;
         idx_in   = idx_ff + 2'd1;
         if (done) begin
            busy_in = 1'b0;
         end
      end
      if (q_pop) begin
         group_in = q_rdata;
         busy_in  = 1'b1;
         idx_in   = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      group_ff <= group_in;
      char_ff  <= char_in;
      lastc_ff <= lastc_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_char  = char_ff;
   assign rsp_last_char = lastc_ff;

endmodule

FILE: design/base64_stream_encoder_unit.sv
// Top level of the base64 stream encoder: front end, group queue and back end.
// Depends on b64se_pkg, b64se_front, b64se_queue and b64se_back.
//
// Encodes a byte stream to standard base64, one byte per req word, last_byte on the final
// byte. Every third byte, or the last byte, closes a 24-bit group that yields four rsp words of
// one ASCII character each, '=' padded for a short final group, last_char on the fourth. A
// byte is taken whenever the group queue is not full; the back end sends one character per
// cycle while rsp_ready lets the output register move on, and that character stage sets the
// sustained input rate. A queue of QueueDepth groups lets the front end keep accepting while
// the back end is stalled, until it fills. A message shorter than three bytes yields nothing
// until its last byte arrives; an empty message yields no characters.
module base64_stream_encoder_unit #(
   parameter int QueueDepth = b64se_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_out_char,
   output logic       rsp_last_char
);
   import b64se_pkg::*;

   group_type q_wdata, q_rdata;
   logic      q_push, q_full, q_pop, q_not_empty;

   b64se_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_wdata       (q_wdata)
   );

   b64se_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .wdata     (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .rdata     (q_rdata)
   );

   b64se_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_not_empty   (q_not_empty),
      .q_rdata       (q_rdata),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for base64_stream_encoder_unit: drives byte words, predicts
// the base64 characters each closed group yields and checks every rsp word in order.
// Depends only on the RTL of the encoder.
`timescale 1ns / 100ps

module tb_top;

   localparam int ORD_UPPER_A = 65;
   localparam int ORD_LOWER_A = 97;
   localparam int ORD_DIGIT_0 = 48;
   localparam int ORD_PLUS    = 43;
   localparam int ORD_SLASH   = 47;
   localparam int ORD_EQUALS  = 61;

   localparam int RANDOM_BYTES  = 300;
   localparam int CALM_TAIL     = 30;
   localparam int HOLD_AFTER    = 100;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 30;
   localparam int STALL_LIMIT   = 2000;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } byte_word_type;

   typedef struct packed {
      logic [6:0] ch;
      logic       last;
   } char_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [6:0] rsp_out_char;
   logic       rsp_last_char;

   byte_word_type tx_bytes[$];
   char_word_type encoded_chars[$];
   char_word_type rx_chars[$];

   // predictor state
   logic [15:0] held_bytes;
   logic [1:0]  held_count;

   int n_total;
   int n_accepted;
   int n_received;
   int n_groups;
   int n_padded;
   int n_messages;
   int errors;
   int stall_cycles;

   base64_stream_encoder_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [6:0] alphabet_char(input logic [5:0] idx);
      int code;
      if (idx < 26) begin
         code = ORD_UPPER_A + idx;
      end else if (idx < 52) begin
         code = ORD_LOWER_A + (idx - 26);
      end else if (idx < 62) begin
         code = ORD_DIGIT_0 + (idx - 52);
      end else if (idx == 62) begin
         code = ORD_PLUS;
      end else begin
         code = ORD_SLASH;
      end
      return code[6:0];
   endfunction

   task automatic encode_byte(input logic [7:0] b, input logic lst);
      logic [23:0] grp;
      int nbytes;
      char_word_type c;
      if (held_count < 2 && !lst) begin
         if (held_count == 0) begin
            held_bytes = {b, 8'h00};
         end else begin
            held_bytes[7:0] = b;
         end
         held_count = held_count + 2'd1;
      end else begin
         case (held_count)
            2'd0: begin
               grp = {b, 16'h0000};
            end
            2'd1: begin
               grp = {held_bytes[15:8], b, 8'h00};
            end
            default: begin
               grp = {held_bytes, b};
            end
         endcase
         nbytes = (held_count == 2'd3) ? 3 : held_count + 1;
         for (int k = 0; k < 4; k++) begin
            c.ch = (k > nbytes) ? ORD_EQUALS[6:0] : alphabet_char(grp[23 - 6 * k -: 6]);
            c.last = (k == 3) && lst;
            encoded_chars.push_back(c);
         end
         n_groups++;
         if (nbytes < 3) n_padded++;
         if (lst) n_messages++;
         held_bytes = 16'h0000;
         held_count = 2'd0;
      end
   endtask

   task automatic add_byte(input logic [7:0] b, input logic lst);
      byte_word_type w;
      w.data = b;
      w.last = lst;
      tx_bytes.push_back(w);
   endtask

   task automatic add_message(input int len);
      logic [7:0] b;
      int style;
      style = $urandom_range(0, 5);
      for (int i = 0; i < len; i++) begin
         if (style == 0) begin
            b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end else if (style == 1) begin
            b = 8'hF8 | 8'($urandom_range(0, 7));
         end else begin
            b = 8'($urandom);
         end
         add_byte(b, i == len - 1);
      end
   endtask

   // driver
   logic drv_idle_on = 1'b0;
   int   drv_gap = 0;

   always @(posedge clock) begin
      logic nv;
      byte_word_type w;
      logic calm;
      nv = req_valid;
      calm = (n_total - n_accepted) <= CALM_TAIL;
      if (reset) begin
         nv = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            encode_byte(req_data_byte, req_last_byte);
            n_accepted++;
         end
         if (!(req_valid && !req_ready)) begin
            if ($urandom_range(0, 63) == 0) drv_idle_on = !drv_idle_on;
            if (drv_gap > 0) begin
               drv_gap--;
               nv = 1'b0;
            end else if (!calm && drv_idle_on && $urandom_range(0, 5) == 0) begin
               drv_gap = $urandom_range(1, 8) - 1;
               nv = 1'b0;
            end else if (tx_bytes.size() > 0) begin
               w = tx_bytes.pop_front();
               nv = 1'b1;
               req_data_byte <= w.data;
               req_last_byte <= w.last;
            end else begin
               nv = 1'b0;
            end
         end
      end
      req_valid <= nv;
   end

   // monitor
   logic mon_idle_on = 1'b0;
   int   mon_gap = 0;
   int   hold_left = 0;
   logic hold_done = 1'b0;

   always @(posedge clock) begin
      logic nr;
      char_word_type c;
      logic calm;
      calm = (n_total - n_accepted) <= CALM_TAIL;
      nr = 1'b1;
      if (reset) begin
         nr = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            c.ch = rsp_out_char;
            c.last = rsp_last_char;
            rx_chars.push_back(c);
            n_received++;
         end
         if ($urandom_range(0, 63) == 0) mon_idle_on = !mon_idle_on;
         if (hold_left > 0) begin
            hold_left--;
            nr = 1'b0;
         end else if (!hold_done && n_received >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            nr = 1'b0;
         end else if (mon_gap > 0) begin
            mon_gap--;
            nr = 1'b0;
         end else if (!calm && mon_idle_on && $urandom_range(0, 5) == 0) begin
            mon_gap = $urandom_range(1, 8) - 1;
            nr = 1'b0;
         end
      end
      rsp_ready <= nr;
   end

   // compare away from the active edge, once both sides have updated
   always @(negedge clock) begin
      char_word_type got;
      char_word_type want;
      while (rx_chars.size() > 0) begin
         got = rx_chars.pop_front();
         if (encoded_chars.size() == 0) begin
            $display("%0t: unexpected word, char %h last %b", $realtime, got.ch, got.last);
            errors++;
         end else begin
            want = encoded_chars.pop_front();
            if (got.ch !== want.ch) begin
               $display("%0t: out_char mismatch, expected %h actual %h",
                        $realtime, want.ch, got.ch);
               errors++;
            end
            if (got.last !== want.last) begin
               $display("%0t: last_char mismatch, expected %b actual %b",
                        $realtime, want.last, got.last);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      int rnd;
      int len;
      held_bytes = 16'h0000;
      held_count = 2'd0;
      n_accepted = 0;
      n_received = 0;
      n_groups = 0;
      n_padded = 0;
      n_messages = 0;
      errors = 0;
      stall_cycles = 0;

      // one byte, two bytes, alphabet ends, full groups, group then tail
      add_byte(8'h00, 1'b1);
      add_byte(8'hFF, 1'b1);
      add_byte(8'hFB, 1'b0);
      add_byte(8'hFF, 1'b1);
      add_byte(8'h4D, 1'b0);
      add_byte(8'h61, 1'b0);
      add_byte(8'h6E, 1'b1);
      add_byte(8'hFF, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(8'hFF, 1'b1);
      add_byte(8'h00, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'h41, 1'b1);
      add_byte(8'h66, 1'b0);
      add_byte(8'h6F, 1'b0);
      add_byte(8'h6F, 1'b0);
      add_byte(8'h62, 1'b0);
      add_byte(8'h61, 1'b1);

      rnd = 0;
      while (rnd < RANDOM_BYTES) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 8);
         add_message(len);
         rnd += len;
      end
      n_total = tx_bytes.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      wait (n_accepted == n_total);
      wait (encoded_chars.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      #1;

      $display("Encoded %0d bytes in %0d messages: %0d groups, %0d padded, %0d characters.",
               n_accepted, n_messages, n_groups, n_padded, n_received);
      $display("Back-pressure hold of %0d cycles applied; %0d mismatches.", HOLD_CYCLES, errors);
      if (errors == 0 && encoded_chars.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
